@@ rtl/priority_interrupt_dispatcher_assert.svh @@
// Assertion macros for the priority interrupt dispatcher.
// Used by pid_ctrl.sv; expects a clock named clk and a reset named rst.
`ifndef PRIORITY_INTERRUPT_DISPATCHER_ASSERT_SVH
`define PRIORITY_INTERRUPT_DISPATCHER_ASSERT_SVH

// same-cycle implication
`define PID_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pid implication check failed");

// next-cycle implication
`define PID_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pid next-cycle check failed");

`endif

@@ rtl/pid_pkg.sv @@
// Package for the priority interrupt dispatcher: constants, codes, types.
// No dependencies; imported by pid_ctrl, pid_dp and the top level.
`default_nettype none

package pid_pkg;

  localparam int NUM_LINES = 32;
  localparam int IDX_W = 5;
  localparam logic [31:0] LINE_MASK = 32'((64'd1 << NUM_LINES) - 64'd1);

  localparam int IN_DATA_W = 40;
  localparam int IN_USER_W = 3;
  localparam int OUT_DATA_W = 88;

  typedef enum logic [2:0] {
    FN_RAISE    = 3'd0,
    FN_REGISTER = 3'd1,
    FN_DISABLE  = 3'd2,
    FN_ENABLE   = 3'd3,
    FN_ENTER    = 3'd4,
    FN_LEAVE    = 3'd5,
    FN_SERVE    = 3'd6,
    FN_NONE     = 3'd7
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // one-hot to index
  function automatic logic [IDX_W-1:0] onehot_index(input logic [31:0] oh);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (oh[i]) idx = idx | IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pid_ctrl.sv @@
// Controller FSM of the priority interrupt dispatcher: input handshake,
// execute sequencing and output valid. Depends on pid_pkg and the assert header.
`default_nettype none
`include "priority_interrupt_dispatcher_assert.svh"

module pid_ctrl import pid_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC: cmd.exec = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  `PID_ASSERT_NXT(a_accept_exec, in_valid && in_ready, state == ST_EXEC)
  `PID_ASSERT_NXT(a_exec_valid, cmd.exec, out_valid && state == ST_IDLE)
  `PID_ASSERT_NXT(a_stall_hold, state == ST_EXEC && out_valid && !out_ready,
                  state == ST_EXEC)
  `PID_ASSERT_IMP(a_cmd_excl, cmd.load, !cmd.exec)

endmodule

`default_nettype wire

@@ rtl/pid_dp.sv @@
// Datapath of the priority interrupt dispatcher: request register, controller
// state (pending, mask, handlers, nesting), serve encoder, result register.
// Depends on pid_pkg.
`default_nettype none

module pid_dp import pid_pkg::*; (
  input  wire                    clk,
  input  wire                    rst,
  input  cmd_t                   cmd,
  input  wire [IN_USER_W-1:0]    in_user,
  input  wire [IN_DATA_W-1:0]    in_data,
  output logic [OUT_DATA_W-1:0]  out_data
);

  // captured request
  func_t             func;
  logic [31:0]       raise_lines;
  logic [IDX_W-1:0]  irq_number;
  logic              handler_present;

  logic [31:0] pending_bits, enable_mask, handler_valid;
  logic [7:0]  critical_count;
  logic        global_enable;

  logic [31:0] pending_next, mask_next, handler_next;
  logic [7:0]  count_next;
  logic        enable_next;

  logic [31:0]      active, lowbit, line_bit;
  logic             line_ok;
  logic             served, invoked, automask, nerr, irq_req;
  logic [IDX_W-1:0] snum;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func            <= func_t'(in_user);
      raise_lines     <= in_data[31:0];
      irq_number      <= in_data[36:32];
      handler_present <= in_data[37];
    end
  end

  always_comb begin
    line_ok  = {1'b0, irq_number} < (IDX_W+1)'(NUM_LINES);
    line_bit = 32'd1 << irq_number;
    active   = pending_bits & enable_mask & LINE_MASK;
    lowbit   = active & (~active + 32'd1);

    pending_next = pending_bits;
    mask_next    = enable_mask;
    handler_next = handler_valid;
    count_next   = critical_count;
    enable_next  = global_enable;
    served   = 1'b0;
    snum     = '0;
    invoked  = 1'b0;
    automask = 1'b0;
    nerr     = 1'b0;

    unique case (func)
      FN_RAISE: pending_next = (pending_bits | raise_lines) & LINE_MASK;
      FN_REGISTER: begin
        if (line_ok) begin
          if (handler_present) begin
            handler_next = handler_valid | line_bit;
            mask_next    = enable_mask | line_bit;
          end else begin
            handler_next = handler_valid & ~line_bit;
            mask_next    = enable_mask & ~line_bit;
          end
        end
      end
      FN_DISABLE: if (line_ok) mask_next = enable_mask & ~line_bit;
      FN_ENABLE:  if (line_ok) mask_next = enable_mask | line_bit;
      FN_ENTER: begin
        enable_next = 1'b0;
        if (critical_count != 8'hFF) count_next = critical_count + 8'd1;
      end
      FN_LEAVE: begin
        if (critical_count == 8'd0) begin
          nerr = 1'b1;
        end else begin
          count_next = critical_count - 8'd1;
          if (critical_count == 8'd1) enable_next = 1'b1;
        end
      end
      FN_SERVE: begin
        if (|active) begin
          served       = 1'b1;
          snum         = onehot_index(lowbit);
          pending_next = pending_bits & ~lowbit;
          if (|(handler_valid & lowbit)) begin
            invoked = 1'b1;
          end else begin
            automask  = 1'b1;
            mask_next = enable_mask & ~lowbit;
          end
        end
      end
      FN_NONE: ;
      default: ;
    endcase

    irq_req = enable_next && |(pending_next & mask_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits   <= '0;
      enable_mask    <= '0;
      handler_valid  <= '0;
      critical_count <= '0;
      global_enable  <= 1'b1;
    end else if (cmd.exec) begin
      pending_bits   <= pending_next;
      enable_mask    <= mask_next;
      handler_valid  <= handler_next;
      critical_count <= count_next;
      global_enable  <= enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data <= {6'd0, pending_next, mask_next, nerr, count_next,
                   automask, invoked, snum, served, irq_req};
    end
  end

endmodule

`default_nettype wire

@@ rtl/priority_interrupt_dispatcher.sv @@
// Priority interrupt dispatcher, top level.
// Instantiates pid_ctrl and pid_dp; depends on pid_pkg.
//
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the function code, s_tdata
//   the line bits, line number and handler flag. One result per request leaves
//   on the m_ stream carrying the flags and the state after that request.
//   Each accepted request is captured in the request register and then
//   executed, which updates state and loads the result register; m_tvalid is
//   high from there until the result is taken. A new request is accepted only
//   after the previous one has executed, as the controller alternates capture
//   and execute. The next request is accepted while a result waits on m_;
//   execution of it holds until that result is taken.
//   Reset (rst, synchronous): pending, mask, handlers and nesting count clear,
//   the global enable is set, no result is valid.
//   If the receiver stalls, the result holds on m_tdata, one further request
//   is taken and parked, then s_tready stays low until m_ drains.
`default_nettype none

module priority_interrupt_dispatcher import pid_pkg::*; (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  // [31:0] raise_lines, [36:32] irq_number, [37] handler_present, [39:38] zero
  input  wire [IN_DATA_W-1:0]   s_tdata,
  // [2:0] func
  input  wire [IN_USER_W-1:0]   s_tuser,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  // [0] irq_request, [1] served, [6:2] served_number, [7] handler_invoked,
  // [8] auto_masked, [16:9] nesting_depth, [17] nesting_error,
  // [49:18] mask_now, [81:50] pending_now, [87:82] zero
  output logic [OUT_DATA_W-1:0] m_tdata
);

  cmd_t cmd;

  pid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  pid_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_user  (s_tuser),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule

`default_nettype wire

@@ tb/priority_interrupt_dispatcher_tb.sv @@
`timescale 1ns / 100ps
// Testbench for priority_interrupt_dispatcher: a directed table, then random requests.
// Each result checks against a typed row or an in-bench predictor. Depends on pid_pkg.

module priority_interrupt_dispatcher_tb;
  import pid_pkg::*;

  typedef struct packed {
    func_t       fn;
    logic [31:0] lines;
    logic [4:0]  num;
    logic        pres;
  } req_t;

  // same layout as m_tdata, lowest field last
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] pending_now;
    logic [31:0] mask_now;
    logic        nesting_error;
    logic [7:0]  nesting_depth;
    logic        auto_masked;
    logic        handler_invoked;
    logic [4:0]  served_number;
    logic        served;
    logic        irq_request;
  } result_t;

  typedef struct packed {
    req_t    rq;
    logic    typed;
    result_t exp;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = FN_NONE;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // predictor state
  logic [31:0] pend_reg;
  logic [31:0] mask_reg;
  logic [31:0] hndl_reg;
  logic [7:0]  depth_reg;
  logic        gie_reg;

  result_t dispatch_q[$];
  row_t    dir_tab[$];

  int  fails = 0;
  int  n_req = 0;
  int  n_served = 0;
  int  n_automask = 0;
  int  n_nerr = 0;
  int  n_sat = 0;
  int  hold_len = 0;
  bit  src_idle = 1'b1;
  bit  sink_idle = 1'b1;

  priority_interrupt_dispatcher dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic result_t quiet_res(input logic irq, input logic [7:0] depth,
                                        input logic nerr, input logic [31:0] mask,
                                        input logic [31:0] pend);
    result_t r;
    r = '0;
    r.irq_request = irq;
    r.nesting_depth = depth;
    r.nesting_error = nerr;
    r.mask_now = mask;
    r.pending_now = pend;
    return r;
  endfunction

  function automatic result_t dispatch_step(input req_t r);
    result_t     res;
    logic [31:0] bit_m;
    logic [31:0] active;
    logic        line_ok;
    res = '0;
    bit_m = 32'd1 << r.num;
    line_ok = int'(r.num) < NUM_LINES;
    case (r.fn)
      FN_RAISE: pend_reg = (pend_reg | r.lines) & LINE_MASK;
      FN_REGISTER: begin
        if (line_ok && r.pres) begin
          hndl_reg |= bit_m;
          mask_reg |= bit_m;
        end else if (line_ok) begin
          hndl_reg &= ~bit_m;
          mask_reg &= ~bit_m;
        end
      end
      FN_DISABLE: if (line_ok) mask_reg &= ~bit_m;
      FN_ENABLE: if (line_ok) mask_reg |= bit_m;
      FN_ENTER: begin
        gie_reg = 1'b0;
        if (depth_reg != 8'hFF) depth_reg++;
      end
      FN_LEAVE: begin
        if (depth_reg == 8'd0) begin
          res.nesting_error = 1'b1;
        end else begin
          depth_reg--;
          if (depth_reg == 8'd0) gie_reg = 1'b1;
        end
      end
      FN_SERVE: begin
        active = pend_reg & mask_reg & LINE_MASK;
        for (int i = 0; i < NUM_LINES; i++) begin
          if (active[i] && !res.served) begin
            res.served = 1'b1;
            res.served_number = 5'(i);
            if (hndl_reg[i]) begin
              res.handler_invoked = 1'b1;
            end else begin
              res.auto_masked = 1'b1;
              mask_reg[i] = 1'b0;
            end
            pend_reg[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.irq_request = gie_reg && ((pend_reg & mask_reg) != 32'd0);
    res.nesting_depth = depth_reg;
    res.mask_now = mask_reg;
    res.pending_now = pend_reg;
    return res;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) r.fn = FN_RAISE;
    else if (pick < 35) r.fn = FN_REGISTER;
    else if (pick < 45) r.fn = FN_DISABLE;
    else if (pick < 58) r.fn = FN_ENABLE;
    else if (pick < 68) r.fn = FN_ENTER;
    else if (pick < 78) r.fn = FN_LEAVE;
    else if (pick < 97) r.fn = FN_SERVE;
    else r.fn = FN_NONE;
    case ($urandom_range(0, 2))
      0: r.lines = $urandom & $urandom & $urandom;
      1: r.lines = 32'd1 << $urandom_range(0, 31);
      default: r.lines = $urandom;
    endcase
    r.num = 5'($urandom_range(0, 31));
    r.pres = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic void cmp_field(input string name, input logic [31:0] e,
                                    input logic [31:0] a);
    if (e !== a) begin
      $error("%s expected %0h actual %0h", name, e, a);
      fails++;
    end
  endfunction

  task automatic send_req(input req_t r, input logic typed, input result_t exp);
    int      gap;
    result_t res;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, r.pres, r.num, r.lines};
    s_tuser <= r.fn;
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    res = dispatch_step(r);
    dispatch_q.push_back(typed ? exp : res);
    n_req++;
    if (res.served) n_served++;
    if (res.auto_masked) n_automask++;
    if (res.nesting_error) n_nerr++;
    if (r.fn == FN_ENTER && res.nesting_depth == 8'hFF) n_sat++;
  endtask

  // result side
  initial begin
    int      stall;
    result_t act;
    result_t exp;
    while (rst) @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = sink_idle ? $urandom_range(0, 11) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      forever begin
        @(posedge clk);
        if (m_tvalid) break;
      end
      act = result_t'(m_tdata);
      if (dispatch_q.size() == 0) begin
        $error("result with no request outstanding: %0h", m_tdata);
        fails++;
      end else begin
        exp = dispatch_q.pop_front();
        cmp_field("irq_request", 32'(exp.irq_request), 32'(act.irq_request));
        cmp_field("served", 32'(exp.served), 32'(act.served));
        cmp_field("served_number", 32'(exp.served_number), 32'(act.served_number));
        cmp_field("handler_invoked", 32'(exp.handler_invoked),
                  32'(act.handler_invoked));
        cmp_field("auto_masked", 32'(exp.auto_masked), 32'(act.auto_masked));
        cmp_field("nesting_depth", 32'(exp.nesting_depth), 32'(act.nesting_depth));
        cmp_field("nesting_error", 32'(exp.nesting_error), 32'(act.nesting_error));
        cmp_field("mask_now", exp.mask_now, act.mask_now);
        cmp_field("pending_now", exp.pending_now, act.pending_now);
      end
      @(negedge clk);
    end
  end

  // request side
  initial begin
    req_t r;
    int   waited;
    pend_reg = '0;
    mask_reg = '0;
    hndl_reg = '0;
    depth_reg = '0;
    gie_reg = 1'b1;

    dir_tab = '{
      '{'{FN_LEAVE,    32'h0000_0000, 5'd0,  1'b0}, 1'b1,
        quiet_res(1'b0, 8'd0, 1'b1, 32'h0, 32'h0)},
      '{'{FN_SERVE,    32'h0000_0000, 5'd0,  1'b0}, 1'b1,
        quiet_res(1'b0, 8'd0, 1'b0, 32'h0, 32'h0)},
      '{'{FN_NONE,     32'hFFFF_FFFF, 5'd31, 1'b1}, 1'b1,
        quiet_res(1'b0, 8'd0, 1'b0, 32'h0, 32'h0)},
      '{'{FN_RAISE,    32'hFFFF_FFFF, 5'd0,  1'b0}, 1'b1,
        quiet_res(1'b0, 8'd0, 1'b0, 32'h0, 32'hFFFF_FFFF)},
      '{'{FN_REGISTER, 32'h0000_0000, 5'd31, 1'b1}, 1'b1,
        quiet_res(1'b1, 8'd0, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF)},
      '{'{FN_REGISTER, 32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_ENABLE,   32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_SERVE,    32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_SERVE,    32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_SERVE,    32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_REGISTER, 32'h0000_0000, 5'd5,  1'b1}, 1'b0, '0},
      '{'{FN_ENTER,    32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_ENTER,    32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_SERVE,    32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_RAISE,    32'h0000_0020, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_LEAVE,    32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_LEAVE,    32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_DISABLE,  32'h0000_0000, 5'd5,  1'b0}, 1'b0, '0},
      '{'{FN_ENABLE,   32'h0000_0000, 5'd5,  1'b0}, 1'b0, '0},
      '{'{FN_REGISTER, 32'h0000_0000, 5'd5,  1'b0}, 1'b0, '0},
      '{'{FN_RAISE,    32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0},
      '{'{FN_DISABLE,  32'h0000_0000, 5'd31, 1'b0}, 1'b0, '0},
      '{'{FN_ENABLE,   32'h0000_0000, 5'd31, 1'b0}, 1'b0, '0},
      '{'{FN_SERVE,    32'h0000_0000, 5'd0,  1'b0}, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < dir_tab.size(); i++)
      send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].exp);

    for (int i = 0; i < 1030; i++) begin
      if (i % 100 == 0) begin
        src_idle = $urandom_range(0, 3) != 0;
        sink_idle = $urandom_range(0, 3) != 0;
      end
      // long receiver hold-off while requests keep coming back to back
      if (i == 400) begin
        hold_len = 80;
        src_idle = 1'b0;
      end
      // drive the count to saturation, then past zero
      if (i == 600) begin
        for (int k = 0; k < 260; k++) begin
          r = rand_req();
          r.fn = FN_ENTER;
          send_req(r, 1'b0, '0);
        end
        for (int k = 0; k < 262; k++) begin
          r = rand_req();
          r.fn = FN_LEAVE;
          send_req(r, 1'b0, '0);
        end
      end
      send_req(rand_req(), 1'b0, '0);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    waited = 0;
    while (dispatch_q.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    if (dispatch_q.size() != 0) begin
      $error("%0d results never arrived", dispatch_q.size());
      fails++;
    end
    repeat (10) @(posedge clk);

    $display("Run covered %0d requests: %0d serves found a line, %0d of them auto-masked,",
             n_req, n_served, n_automask);
    $display("%0d leaves at zero depth, %0d enters at full depth", n_nerr, n_sat);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
